// File: src/rpa_pkg.sv
package rpa_pkg;

  // Fixed field widths
  localparam int ADDR_W      = 27;
  localparam int CNT_W       = 8;
  localparam int STAT_W      = 3;
  localparam int ACT_W       = 2;
  localparam int FUP_W       = 15;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;
  localparam logic [CNT_W-1:0] CNT_ONE = 8'd1;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_DROP  = 2'd1,
    ACT_SHARE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_RELEASED  = 3'd1,
    ST_OOM       = 3'd2,
    ST_BADADDR   = 3'd3,
    ST_UNDERFLOW = 3'd4,
    ST_UNOWNED   = 3'd5,
    ST_OVERFLOW  = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_en;   // write zero to one count entry
    logic load;       // capture an input word
    logic read;       // read count and stack memories
    logic commit;     // update state and load the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last; // clearing pass at its last entry
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

// File: src/rpa_ctrl.sv
module rpa_ctrl
  import rpa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // finish when the output register is free; take the next word at once
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          in_tready  = 1'b1;
          if (in_tvalid) begin
            cmd.load  = 1'b1;
            state_nxt = S_READ;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// File: src/rpa_dp.sv
module rpa_dp
  import rpa_pkg::*;
#(
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [ADDR_W-1:0]      in_address,
  input  logic [ACT_W-1:0]       in_action,
  input  logic                   cfg_we,
  input  logic [FUP_W-1:0]       cfg_wdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [STAT_W-1:0]      out_tuser
);

  localparam int PW     = $clog2(NUM_PAGES);
  localparam int PB_LOG = $clog2(PAGE_BYTES);

  // memories
  logic [CNT_W-1:0] cnt_mem [NUM_PAGES];
  logic [PW-1:0]    stk_mem [NUM_PAGES];

  // control state
  logic [FUP_W-1:0] fup_r;
  logic [PW:0]      depth_r, depth_nxt;
  logic [PW-1:0]    unext_r, unext_nxt;
  logic             uleft_r, uleft_nxt;
  logic [PW-1:0]    clr_r;
  logic             out_valid_r;

  // payload
  action_t          act_r;
  logic [PW-1:0]    page_r;
  logic             bad_r;
  logic [CNT_W-1:0] cnt_q;
  logic [PW-1:0]    stk_q;
  logic [ADDR_W-1:0] res_addr_r;
  logic [CNT_W-1:0]  res_cnt_r;
  status_t           res_st_r;

  // decode and result logic
  logic [31:0]       idx32;
  logic              bad_nxt;
  logic [PW-1:0]     stk_ra;
  logic              cnt_we;
  logic [PW-1:0]     cnt_wa;
  logic [CNT_W-1:0]  cnt_wd;
  logic              stk_we;
  logic [PW-1:0]     alloc_page;
  logic              alloc_ok;
  logic [ADDR_W-1:0] res_addr;
  logic [CNT_W-1:0]  res_cnt;
  status_t           res_st;

  // address check: aligned, at or above first usable page, below page count
  assign idx32   = 32'(in_address >> PB_LOG);
  assign bad_nxt = (in_address[PB_LOG-1:0] != '0) ||
                   (idx32 < 32'(fup_r)) || (idx32 >= 32'(NUM_PAGES));
  assign stk_ra  = PW'(depth_r - 1'b1);

  assign sts.clear_last = (clr_r == PW'(NUM_PAGES - 1));
  assign sts.out_free   = !out_valid_r || out_tready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fup_r <= '0;
    end else if (cfg_we) begin
      fup_r <= cfg_wdata;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= action_t'(in_action);
      page_r <= idx32[PW-1:0];
      bad_r  <= bad_nxt;
    end
  end

  // operation decode
  always_comb begin
    res_addr   = '0;
    res_cnt    = '0;
    res_st     = ST_OK;
    cnt_we     = 1'b0;
    cnt_wa     = page_r;
    cnt_wd     = '0;
    stk_we     = 1'b0;
    depth_nxt  = depth_r;
    unext_nxt  = unext_r;
    uleft_nxt  = uleft_r;
    alloc_page = '0;
    alloc_ok   = 1'b0;
    if (cmd.clear_en) begin
      cnt_we = 1'b1;
      cnt_wa = clr_r;
    end else if (cmd.commit) begin
      if (act_r == ACT_ALLOC) begin
        // freed pages first, then the countdown of never-used pages
        if (depth_r != '0) begin
          alloc_page = stk_q;
          alloc_ok   = 1'b1;
          depth_nxt  = depth_r - 1'b1;
        end else if (uleft_r && (32'(unext_r) >= 32'(fup_r))) begin
          alloc_page = unext_r;
          alloc_ok   = 1'b1;
          if (unext_r == '0) begin
            uleft_nxt = 1'b0;
          end else begin
            unext_nxt = unext_r - 1'b1;
          end
        end
        if (alloc_ok) begin
          cnt_we   = 1'b1;
          cnt_wa   = alloc_page;
          cnt_wd   = CNT_ONE;
          res_addr = ADDR_W'(64'(alloc_page) << PB_LOG);
          res_cnt  = CNT_ONE;
        end else begin
          res_st = ST_OOM;
        end
      end else if (bad_r) begin
        res_st = ST_BADADDR;
      end else begin
        case (act_r)
          ACT_DROP: begin
            if (cnt_q == '0) begin
              res_st = ST_UNDERFLOW;
            end else begin
              cnt_we = 1'b1;
              cnt_wd = cnt_q - 1'b1;
              if (cnt_q == CNT_ONE) begin
                // last reference: page goes back on the stack
                stk_we    = 1'b1;
                depth_nxt = depth_r + 1'b1;
                res_st    = ST_RELEASED;
              end else begin
                res_cnt = cnt_q - 1'b1;
              end
            end
          end
          ACT_SHARE: begin
            if (cnt_q == '0) begin
              res_st = ST_UNOWNED;
            end else if (cnt_q == CNT_MAX) begin
              res_st  = ST_OVERFLOW;
              res_cnt = CNT_MAX;
            end else begin
              cnt_we  = 1'b1;
              cnt_wd  = cnt_q + 1'b1;
              res_cnt = cnt_q + 1'b1;
            end
          end
          default: begin
            res_cnt = cnt_q;
          end
        endcase
      end
    end
  end

  // count memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cmd.read) begin
      cnt_q <= cnt_mem[page_r];
    end
  end

  // freed page stack
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[depth_r[PW-1:0]] <= page_r;
    end
    if (cmd.read) begin
      stk_q <= stk_mem[stk_ra];
    end
  end

  // allocator state and clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      unext_r <= PW'(NUM_PAGES - 1);
      uleft_r <= 1'b1;
      clr_r   <= '0;
    end else begin
      depth_r <= depth_nxt;
      unext_r <= unext_nxt;
      uleft_r <= uleft_nxt;
      if (cmd.clear_en) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_addr_r <= res_addr;
      res_cnt_r  <= res_cnt;
      res_st_r   <= res_st;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - ADDR_W - CNT_W){1'b0}}, res_cnt_r, res_addr_r};
  assign out_tuser  = res_st_r;

endmodule

// File: src/refcounted_page_allocator.sv
// Page allocator with per-page reference counts.
// Input words: in_tuser carries the action (allocate, drop reference, add
// sharer, read count), in_tdata the page byte address (ignored on allocate).
// Each word gives exactly one output word: out_tdata holds page_address and
// ref_count, out_tuser the status code.
// Flow: a word goes through the count/stack memory read (S_READ), then the
// read-modify-write and result load (S_EXEC); out_tvalid rises once S_EXEC
// commits. S_EXEC waits while the output register is full and takes the next
// word as it commits. The count memory read followed by its write sets this order.
// Reset: after rst_n the count memory is cleared one entry per cycle, all
// NUM_PAGES entries, while in_tready stays low; cfg writes are taken anytime.
// The free list starts empty and allocation counts down from the top page.
// Stall: the result sits in an output register; with out_tready low the
// block still takes one more word and holds it until the register frees.
// cfg_wdata sets first_usable_page; write it only while the block is idle.
module refcounted_page_allocator
  import rpa_pkg::*;
#(
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [26:0] address
  input  logic [ACT_W-1:0]       in_tuser,   // [1:0] action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [26:0] page_address, [34:27] ref_count
  output logic [STAT_W-1:0]      out_tuser,  // [2:0] status
  input  logic                   cfg_we,
  input  logic [FUP_W-1:0]       cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  rpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rpa_dp #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_address (in_tdata[ADDR_W-1:0]),
    .in_action  (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
